[rtl/core/ptw_pkg.sv]
// Shared types and constants for the Sv32 page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

   // Request operation codes.
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_READ_RESP = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_FAULT = 2'd2;

   // Fault codes.
   localparam logic [1:0] FAULT_NONE        = 2'd0;
   localparam logic [1:0] FAULT_INVALID_L1  = 2'd1;
   localparam logic [1:0] FAULT_INVALID_L2  = 2'd2;
   localparam logic [1:0] FAULT_NONLEAF_L2  = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSLATION_ON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_PAGE      = 2'd1;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned PPN_W  = 20;
   localparam int unsigned VPN_W  = 10;
   localparam int unsigned OFF_W  = 12;

   // Walk state, one-hot.
   typedef enum logic [2:0] {
      WALK_IDLE = 3'b001,
      WALK_L1   = 3'b010,
      WALK_L2   = 3'b100
   } walk_state_type;

   // Outcome of processing one request.
   typedef struct packed {
      logic                has_result;
      logic [1:0]          kind;
      logic [ADDR_W-1:0]   address;
      logic [1:0]          fault_code;
      walk_state_type      next_state;
      logic                capture_vaddr;
   } step_result_type;

endpackage

[rtl/core/ptw_if.sv]
// Channel interfaces for the walker: request, response and configuration write.
`timescale 1ns / 1ps

interface ptw_req_if import ptw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [ADDR_W-1:0] virt_addr;
   logic [ADDR_W-1:0] read_data;

   modport source (output valid, output op, output virt_addr, output read_data,
                   input ready);
   modport sink   (input valid, input op, input virt_addr, input read_data,
                   output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [ADDR_W-1:0] address;
   logic [1:0]        fault_code;

   modport source (output valid, output kind, output address, output fault_code,
                   input ready);
   modport sink   (input valid, input kind, input address, input fault_code,
                   output ready);
endinterface

interface ptw_csr_if import ptw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/ptw_step.sv]
// Combinational walk step: decides the result and next walk state for one request.
`timescale 1ns / 1ps

module ptw_step import ptw_pkg::*; (
   input  logic              op,
   input  logic [ADDR_W-1:0] virt_addr,
   input  logic [ADDR_W-1:0] read_data,
   input  logic              translation_on,
   input  logic [PPN_W-1:0]  root_page,
   input  walk_state_type    state,
   input  logic [ADDR_W-1:0] pending_vaddr,
   output step_result_type   result
);

   logic [VPN_W-1:0] vpn1;
   logic [VPN_W-1:0] vpn0;
   logic [OFF_W-1:0] offset;
   logic             pte_valid;
   logic             pte_leaf;

   assign vpn1      = virt_addr[31:22];
   assign vpn0      = pending_vaddr[21:12];
   assign offset    = pending_vaddr[11:0];
   assign pte_valid = read_data[0];
   assign pte_leaf  = |read_data[3:1];

   // Decode the request against the current walk state.
   always_comb begin
      result.has_result    = 1'b0;
      result.kind          = KIND_READ;
      result.address       = '0;
      result.fault_code    = FAULT_NONE;
      result.next_state    = WALK_IDLE;
      result.capture_vaddr = 1'b0;
      if (op == OP_TRANSLATE) begin
         result.has_result = 1'b1;
         if (!translation_on) begin
            // Bare mode passes the address straight through.
            result.kind    = KIND_DONE;
            result.address = virt_addr;
         end else begin
            // Start a walk with a read of the first-level entry.
            result.kind          = KIND_READ;
            result.address       = {root_page, vpn1, 2'b00};
            result.next_state    = WALK_L1;
            result.capture_vaddr = 1'b1;
         end
      end else begin
         case (state)
            WALK_L1: begin
               result.has_result = 1'b1;
               if (!pte_valid) begin
                  result.kind       = KIND_FAULT;
                  result.address    = pending_vaddr;
                  result.fault_code = FAULT_INVALID_L1;
               end else if (pte_leaf) begin
                  // Superpage: middle index comes from the virtual address.
                  result.kind    = KIND_DONE;
                  result.address = {read_data[29:20], vpn0, offset};
               end else begin
                  result.kind       = KIND_READ;
                  result.address    = {read_data[29:10], vpn0, 2'b00};
                  result.next_state = WALK_L2;
               end
            end
            WALK_L2: begin
               result.has_result = 1'b1;
               if (!pte_valid) begin
                  result.kind       = KIND_FAULT;
                  result.address    = pending_vaddr;
                  result.fault_code = FAULT_INVALID_L2;
               end else if (!pte_leaf) begin
                  result.kind       = KIND_FAULT;
                  result.address    = pending_vaddr;
                  result.fault_code = FAULT_NONLEAF_L2;
               end else begin
                  result.kind    = KIND_DONE;
                  result.address = {read_data[29:10], offset};
               end
            end
            default: begin
               // A response with no walk pending is dropped.
               result.has_result = 1'b0;
            end
         endcase
      end
   end

endmodule

[rtl/core/sv32_page_table_walker_core.sv]
// Top level of the Sv32 page table walker: input stage, walk state and result stage.
`timescale 1ns / 1ps

// Sv32 page table walker.
// The req_chan channel carries either a translate request (op 0, virt_addr)
// or a memory read response (op 1, read_data) for the entry last asked for.
// Each request gives at most one result on rsp_chan: a memory read request
// with the entry address, a finished translation with the physical address,
// or a fault with the walk's virtual address and a fault code. A response
// that arrives while no walk is pending gives no result.
// The csr_chan channel writes the translation enable and the root page
// number; write it only while the walker is idle. It is always ready.
// An accepted request passes through the input register, then the decode
// logic feeds the result register. Throughput is one request per cycle
// while the receiver takes results, set by the single decode stage.
// When the receiver stalls, the result register holds and the input
// register keeps one more request; req_chan.ready drops only when both
// are full. Reset clears the valid flags of both registers, the
// configuration and the walk state, leaving the walker idle in bare mode.

module sv32_page_table_walker_core import ptw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ptw_req_if.sink       req_chan,
   ptw_rsp_if.source     rsp_chan,
   ptw_csr_if.sink       csr_chan
);

   logic              in_valid_ff,  in_valid_in;
   logic              in_op_ff,     in_op_in;
   logic [ADDR_W-1:0] in_vaddr_ff,  in_vaddr_in;
   logic [ADDR_W-1:0] in_data_ff,   in_data_in;

   logic              trans_on_ff,  trans_on_in;
   logic [PPN_W-1:0]  root_page_ff, root_page_in;
   walk_state_type    walk_ff,      walk_in;
   logic [ADDR_W-1:0] pend_vaddr_ff, pend_vaddr_in;

   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_kind_ff,  out_kind_in;
   logic [ADDR_W-1:0] out_addr_ff,  out_addr_in;
   logic [1:0]        out_fault_ff, out_fault_in;

   logic              advance;
   logic              req_take;
   step_result_type   step;

   // The input stage moves on whenever the result register is free or drains.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_vaddr_in = in_vaddr_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_op_in    = req_chan.op;
         in_vaddr_in = req_chan.virt_addr;
         in_data_in  = req_chan.read_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Configuration writes; indexes past the list are ignored.
   assign csr_chan.ready = 1'b1;
   always_comb begin
      trans_on_in  = trans_on_ff;
      root_page_in = root_page_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_TRANSLATION_ON: trans_on_in  = csr_chan.data[0];
            CSR_ROOT_PAGE:      root_page_in = csr_chan.data[PPN_W-1:0];
            default: begin
               trans_on_in = trans_on_ff;
            end
         endcase
      end
   end

   ptw_step u_step (
      .op             (in_op_ff),
      .virt_addr      (in_vaddr_ff),
      .read_data      (in_data_ff),
      .translation_on (trans_on_ff),
      .root_page      (root_page_ff),
      .state          (walk_ff),
      .pending_vaddr  (pend_vaddr_ff),
      .result         (step)
   );

   // Walk state follows each processed request.
   always_comb begin
      walk_in       = walk_ff;
      pend_vaddr_in = pend_vaddr_ff;
      if (advance) begin
         walk_in = step.next_state;
         if (step.capture_vaddr) begin
            pend_vaddr_in = in_vaddr_ff;
         end
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_addr_in  = out_addr_ff;
      out_fault_in = out_fault_ff;
      if (advance) begin
         out_valid_in = step.has_result;
         out_kind_in  = step.kind;
         out_addr_in  = step.address;
         out_fault_in = step.fault_code;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kind       = out_kind_ff;
   assign rsp_chan.address    = out_addr_ff;
   assign rsp_chan.fault_code = out_fault_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         trans_on_ff   <= 1'b0;
         root_page_ff  <= '0;
         walk_ff       <= WALK_IDLE;
         pend_vaddr_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         trans_on_ff   <= trans_on_in;
         root_page_ff  <= root_page_in;
         walk_ff       <= walk_in;
         pend_vaddr_ff <= pend_vaddr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_op_ff     <= in_op_in;
      in_vaddr_ff  <= in_vaddr_in;
      in_data_ff   <= in_data_in;
      out_kind_ff  <= out_kind_in;
      out_addr_ff  <= out_addr_in;
      out_fault_ff <= out_fault_in;
   end

endmodule
